// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; each assumes signals named clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ABA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/aba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aba_pkg
// Types, field widths and codes shared by the bump allocator modules.
// ----------------------------------------------------------------------------
package aba_pkg;

  localparam int SIZE_W     = 28;
  localparam int ALIGN_W    = 13;
  localparam int PAD_W      = ALIGN_W - 1;
  localparam int NEED_W     = SIZE_W + 1;
  localparam int ADDR_W     = 32;
  localparam int STAT_W     = 2;
  localparam int TOTAL_W    = 28;
  localparam int INIT_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ACC_W      = 64;
  localparam int ADDR_BITS  = 32;

  localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                            ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ALIGN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_LIMIT     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROWABLE     = 2'd2;

  localparam logic [INIT_W-1:0]  INIT_SIZE_RESET = 21'd4096;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = {TOTAL_W{1'b1}};

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] sum;
    logic             carry;
  } alu_rsp_t;

  typedef struct packed {
    logic               command;
    logic [SIZE_W-1:0]  alloc_size;
    logic [ALIGN_W-1:0] align;
  } aba_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [STAT_W-1:0]  status;
    logic [TOTAL_W-1:0] used_total;
    logic [TOTAL_W-1:0] capacity_total;
  } aba_out_t;

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [ACC_W-1:0] v);
    return (v > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : v[TOTAL_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/aba_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aba_alu
// Shared 64-bit add/subtract unit; carry out is set when a >= b on subtract.
// ----------------------------------------------------------------------------
module aba_alu import aba_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ACC_W-1:0] b_eff;
  logic             cin;

  always_comb begin
    b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
    cin   = (req.op == ALU_SUB);
    {rsp.carry, rsp.sum} = {1'b0, req.a} + {1'b0, b_eff} + (ACC_W + 1)'(cin);
  end

endmodule

// ===== hw/rtl/aligned_bump_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_bump_allocator
// Aligned bump allocator over a chain of doubling blocks laid out from
// region_base. One word in gives one word out. All address and usage
// arithmetic runs through a single shared 64-bit adder stepped by a small
// sequencer, so the input is stalled while a word is in work. A rewind
// command or a bad alignment passes through S_CAP and S_DONE; an allocation
// that fits walks S_BSZ to S_FIT, then S_COMMIT, S_CAP and S_DONE; each
// block it has to move past (existing or newly made) adds S_GAP, S_MOVE
// and a new walk from S_BSZ, at most MAX_BLOCKS - 1 times. A finished
// result sits in the output register while the next word is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aligned_bump_allocator import aba_pkg::*; #(
  parameter int MAX_BLOCKS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  aba_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output aba_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CB_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BM_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CAP_W = INIT_W + MAX_BLOCKS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BSZ,
    S_BASE,
    S_POS,
    S_ALN,
    S_NEED,
    S_TOT,
    S_FIT,
    S_COMMIT,
    S_GAP,
    S_MOVE,
    S_CAP,
    S_DONE
  } state_t;

  state_t             state;
  logic [CB_W-1:0]    cur;
  logic [BM_W-1:0]    bm;
  logic [CAP_W-1:0]   block_used;
  logic [ACC_W-1:0]   total_used;
  logic [CAP_W-1:0]   bsz;
  logic [ACC_W-1:0]   acc;
  logic [PAD_W-1:0]   pad_r;
  logic [NEED_W-1:0]  need;
  logic [ADDR_W-1:0]  aligned_addr;
  logic [ADDR_W-1:0]  addr_r;
  logic [STAT_W-1:0]  status_r;
  logic               grow;
  aba_in_t            item;
  logic [ADDR_W-1:0]  region_base;
  logic [INIT_W-1:0]  init_size;
  logic               growable;

  logic [CAP_W-1:0]   bsz_now;
  logic [CAP_W-1:0]   cap_shift;
  logic [PAD_W-1:0]   amask;
  logic [PAD_W-1:0]   pad;
  logic               in_accept;
  logic               more_blocks;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  aba_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign bsz_now     = CAP_W'(init_size) << cur;
  assign cap_shift   = CAP_W'(init_size) << bm;
  assign amask       = PAD_W'(item.align - 1'b1);
  // padding up to the alignment only depends on the low bits of the position
  assign pad         = (~acc[PAD_W-1:0] + 1'b1) & amask;
  assign more_blocks = ((BM_W + 1)'(cur) + 1'b1) < (BM_W + 1)'(bm);

  // operand steering for the shared adder
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state)
      S_BSZ: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ACC_W'(bsz_now);
        alu_req.b  = ACC_W'(init_size);
      end
      S_BASE: begin
        alu_req.a = acc;
        alu_req.b = ACC_W'(region_base);
      end
      S_POS: begin
        alu_req.a = acc;
        alu_req.b = ACC_W'(block_used);
      end
      S_ALN: begin
        alu_req.a = acc;
        alu_req.b = ACC_W'(pad);
      end
      S_NEED: begin
        alu_req.a = ACC_W'(pad_r);
        alu_req.b = ACC_W'(item.alloc_size);
      end
      S_TOT: begin
        alu_req.a = ACC_W'(need);
        alu_req.b = ACC_W'(block_used);
      end
      S_FIT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ACC_W'(bsz);
        alu_req.b  = acc;
      end
      S_COMMIT: begin
        alu_req.a = total_used;
        alu_req.b = ACC_W'(need);
      end
      S_GAP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ACC_W'(bsz);
        alu_req.b  = ACC_W'(block_used);
      end
      S_MOVE: begin
        alu_req.a = total_used;
        alu_req.b = acc;
      end
      S_CAP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = ACC_W'(cap_shift);
        alu_req.b  = ACC_W'(init_size);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur         <= '0;
      bm          <= BM_W'(1);
      block_used  <= '0;
      total_used  <= '0;
      region_base <= '0;
      init_size   <= INIT_SIZE_RESET;
      growable    <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REGION_BASE:  region_base <= cfg_data[ADDR_W-1:0];
          REG_INITIAL_SIZE: init_size   <= cfg_data[INIT_W-1:0];
          REG_GROWABLE:     growable    <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // in S_DONE the output register is refilled below instead
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            item     <= in_data;
            addr_r   <= '0;
            status_r <= STAT_OK;
            if (in_data.command == CMD_RESET) begin
              cur        <= '0;
              block_used <= '0;
              total_used <= '0;
              state      <= S_CAP;
            end else if ((in_data.align == '0) ||
                         ((in_data.align & (in_data.align - 1'b1)) != '0)) begin
              status_r <= STAT_BAD_ALIGN;
              state    <= S_CAP;
            end else begin
              state <= S_BSZ;
            end
          end
        end
        S_BSZ: begin
          bsz   <= bsz_now;
          acc   <= alu_rsp.sum;
          state <= S_BASE;
        end
        S_BASE: begin
          acc   <= alu_rsp.sum;
          state <= S_POS;
        end
        S_POS: begin
          acc   <= alu_rsp.sum;
          state <= S_ALN;
        end
        S_ALN: begin
          aligned_addr <= alu_rsp.sum[ADDR_W-1:0] & ADDR_MASK;
          pad_r        <= pad;
          state        <= S_NEED;
        end
        S_NEED: begin
          need  <= alu_rsp.sum[NEED_W-1:0];
          state <= S_TOT;
        end
        S_TOT: begin
          acc   <= alu_rsp.sum;
          state <= S_FIT;
        end
        S_FIT: begin
          // carry set: bsz >= used + need
          if (alu_rsp.carry) begin
            block_used <= acc[CAP_W-1:0];
            state      <= S_COMMIT;
          end else if (!growable) begin
            status_r <= STAT_NO_SPACE;
            state    <= S_CAP;
          end else if (more_blocks) begin
            grow  <= 1'b0;
            state <= S_GAP;
          end else if (bm >= BM_W'(MAX_BLOCKS)) begin
            status_r <= STAT_LIMIT;
            state    <= S_CAP;
          end else begin
            grow  <= 1'b1;
            state <= S_GAP;
          end
        end
        S_COMMIT: begin
          total_used <= alu_rsp.sum;
          addr_r     <= aligned_addr;
          state      <= S_CAP;
        end
        S_GAP: begin
          // tail of the block is written off as used
          acc   <= alu_rsp.sum;
          state <= S_MOVE;
        end
        S_MOVE: begin
          total_used <= alu_rsp.sum;
          cur        <= cur + 1'b1;
          block_used <= '0;
          if (grow) begin
            bm <= bm + 1'b1;
          end
          state <= S_BSZ;
        end
        S_CAP: begin
          acc   <= alu_rsp.sum;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data.address        <= addr_r;
            out_data.status         <= status_r;
            out_data.used_total     <= sat_total(total_used);
            out_data.capacity_total <= sat_total(acc);
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ABA_ASSERT_IMPL(a_blocks_sane, 1'b1, (cur < bm) && (bm <= MAX_BLOCKS), "block count out of range")
  `ABA_ASSERT_NEXT(a_move_clears, state == S_MOVE, (block_used == '0) && (state == S_BSZ), "move did not restart block")
  `ABA_ASSERT_NEXT(a_result_held, (state == S_DONE) && out_valid && out_stall, state == S_DONE, "result overwrote pending word")
  `ABA_ASSERT_NEXT(a_rewind, in_accept && (in_data.command == CMD_RESET), (cur == '0) && (total_used == '0), "rewind did not clear usage")

endmodule
